FILE: sv/hns_pkg.sv
// Shared types, constants and command structs of the heightmap normal stream.
package hns_pkg;

  localparam int MaxWidth = 1024;
  localparam int MaxRows  = 4096;
  localparam int XW       = $clog2(MaxWidth);   // column index bits
  localparam int YW       = $clog2(MaxRows) + 1; // row counter bits, holds MaxRows
  localparam int WCFG     = 11;
  localparam int HCFG     = 13;
  localparam int SCFG     = 16;
  localparam int SUMW     = 10;                  // r+g+b
  localparam int MAGW     = 26;                  // scale * sum difference
  localparam int SQW      = 52;
  localparam int WIDE     = 88;                  // search accumulators
  localparam int QW       = 15;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SCALE  = 2'd2;

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  // Y component magnitude is 2 * 765 * 256, so its square is a constant.
  localparam logic [SQW-1:0] AY_SQ = 52'd153413222400;
  localparam logic [QW-1:0]  Q_MAX = 15'd16384;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_t;

  typedef struct packed {
    logic signed [15:0] norm_x;
    logic [14:0]        norm_y;
    logic signed [15:0] norm_z;
    logic [9:0]         column;
    logic [11:0]        row;
    logic               end_of_image;
  } out_t;

  typedef struct packed {
    logic       accept;
    logic       commit;
    logic       square;
    logic       length;
    logic       init;
    logic       cand;
    logic       decide;
    logic       store;
    logic [1:0] comp;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/hns_ctrl.sv
// Sequencer of the normal stream: steps the datapath through one item.
module hns_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  hns_pkg::sts_t sts,
  output hns_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_LEN  = 3'd3;
  localparam logic [2:0] S_INIT = 3'd4;
  localparam logic [2:0] S_CAND = 3'd5;
  localparam logic [2:0] S_DEC  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic [3:0] step_r, step_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    comp_nxt  = comp_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.comp  = comp_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.commit = 1'b1;
        state_nxt  = sts.emit ? S_MUL2 : S_IDLE;
      end
      S_MUL2: begin
        cmd.square = 1'b1;
        state_nxt  = S_LEN;
      end
      S_LEN: begin
        cmd.length = 1'b1;
        comp_nxt   = hns_pkg::COMP_X;
        state_nxt  = S_INIT;
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        step_nxt  = '0;
        state_nxt = S_CAND;
      end
      S_CAND: begin
        cmd.cand  = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        if (step_r == 4'(hns_pkg::QW - 1)) begin
          cmd.store = 1'b1;
          if (comp_r == hns_pkg::COMP_Z) begin
            state_nxt = S_OUT;
          end else begin
            comp_nxt  = comp_r + 2'd1;
            state_nxt = S_INIT;
          end
        end else begin
          step_nxt  = step_r + 4'd1;
          state_nxt = S_CAND;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      comp_r  <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      comp_r  <= comp_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

FILE: sv/hns_dpath.sv
// Datapath: row buffers, counters, squares and the bit-serial normalizer.
module hns_dpath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [hns_pkg::SCFG-1:0] cfg_data,
  input  hns_pkg::in_t             in_data,
  output hns_pkg::out_t            out_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  input  hns_pkg::cmd_t            cmd,
  output hns_pkg::sts_t            sts
);

  localparam int XW = hns_pkg::XW;
  localparam int YW = hns_pkg::YW;
  localparam int WIDE = hns_pkg::WIDE;

  logic [hns_pkg::WCFG-1:0] width_r;
  logic [hns_pkg::HCFG-1:0] height_r;
  logic [hns_pkg::SCFG-1:0] scale_r;

  logic [hns_pkg::SUMW-1:0] upper_mem [hns_pkg::MaxWidth];
  logic [hns_pkg::SUMW-1:0] mid_mem   [hns_pkg::MaxWidth];

  logic [XW-1:0] col_r;
  logic [YW-1:0] row_r;
  logic [hns_pkg::SUMW-1:0] left_mid_r;

  logic [XW:0]   w_eff;
  logic [YW-1:0] h_eff;
  logic [XW-1:0] x_cur;
  logic [YW-1:0] y_cur;
  logic [XW:0]   x_plus;

  // Latched per item.
  logic [XW-1:0] x_r;
  logic [YW-1:0] y_r;
  logic [XW:0]   w_r;
  logic          flush_r;
  logic [hns_pkg::SUMW-1:0] cur_r, here_r, right_r, above_r;

  logic [hns_pkg::SUMW-1:0] m_left, m_right, above;
  logic [hns_pkg::SUMW-1:0] dx, dz;
  logic nx_r, nz_r;
  logic [hns_pkg::MAGW-1:0] ax_r, az_r;
  logic [hns_pkg::SQW-1:0]  ax2_r, az2_r;
  logic signed [WIDE-1:0] len2_r;

  logic signed [WIDE-1:0] u_r, a_r, b_r, r_r, uc_r;
  logic [hns_pkg::QW-1:0] q_r, bit_r, qc_r;
  logic [hns_pkg::QW-1:0] q_dec;
  logic                   take;
  logic [hns_pkg::SQW-1:0] mag2;
  logic [hns_pkg::QW-1:0] res_r [3];

  hns_pkg::out_t out_r;
  logic          out_valid_r;

  // Effective dimensions, clamped into range.
  always_comb begin
    if (width_r == '0)
      w_eff = (XW+1)'(1);
    else if (width_r > hns_pkg::WCFG'(hns_pkg::MaxWidth))
      w_eff = (XW+1)'(hns_pkg::MaxWidth);
    else
      w_eff = (XW+1)'(width_r);
    if (height_r == '0)
      h_eff = YW'(1);
    else if (height_r > hns_pkg::HCFG'(hns_pkg::MaxRows))
      h_eff = YW'(hns_pkg::MaxRows);
    else
      h_eff = YW'(height_r);
    x_cur  = ((XW+1)'(col_r) >= w_eff) ? XW'(w_eff - (XW+1)'(1)) : col_r;
    y_cur  = (row_r > h_eff) ? h_eff : row_r;
    x_plus = (XW+1)'(x_cur) + (XW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= hns_pkg::WCFG'(1024);
      height_r <= hns_pkg::HCFG'(1024);
      scale_r  <= hns_pkg::SCFG'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        hns_pkg::CFG_WIDTH:  width_r  <= cfg_data[hns_pkg::WCFG-1:0];
        hns_pkg::CFG_HEIGHT: height_r <= cfg_data[hns_pkg::HCFG-1:0];
        hns_pkg::CFG_SCALE:  scale_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the item and read the row buffers; on commit, write them back.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r     <= x_cur;
      y_r     <= y_cur;
      w_r     <= w_eff;
      flush_r <= (y_cur == h_eff);
      cur_r   <= (y_cur == h_eff) ? '0 :
                 hns_pkg::SUMW'(in_data.red) + hns_pkg::SUMW'(in_data.green) +
                 hns_pkg::SUMW'(in_data.blue);
      here_r  <= mid_mem[x_cur];
      right_r <= mid_mem[x_plus[XW-1:0]];
      above_r <= upper_mem[x_cur];
    end
    if (cmd.commit) begin
      upper_mem[x_r] <= here_r;
      mid_mem[x_r]   <= cur_r;
    end
  end

  assign m_left  = (x_r != '0) ? left_mid_r : '0;
  assign m_right = (((XW+1)'(x_r) + (XW+1)'(1)) < w_r) ? right_r : '0;
  assign above   = (y_r >= YW'(2)) ? above_r : '0;
  assign dx = (m_left < m_right) ? (m_right - m_left) : (m_left - m_right);
  assign dz = (above < cur_r) ? (cur_r - above) : (above - cur_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      left_mid_r <= '0;
    end else if (cmd.commit) begin
      left_mid_r <= here_r;
      if (((XW+1)'(x_r) + (XW+1)'(1)) >= w_r) begin
        col_r <= '0;
        row_r <= flush_r ? '0 : y_r + YW'(1);
      end else begin
        col_r <= x_r + XW'(1);
        row_r <= y_r;
      end
    end
  end

  assign sts.emit = (y_r != '0);

  // Component signs, magnitudes, their squares and the squared length.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      nx_r <= (m_left < m_right);
      nz_r <= (above < cur_r);
      ax_r <= hns_pkg::MAGW'(scale_r * dx);
      az_r <= hns_pkg::MAGW'(scale_r * dz);
    end
    if (cmd.square) begin
      ax2_r <= ax_r * ax_r;
      az2_r <= az_r * az_r;
    end
    if (cmd.length)
      len2_r <= WIDE'(ax2_r) + WIDE'(az2_r) + WIDE'(hns_pkg::AY_SQ);
  end

  // Largest q <= 16384 with (2q-1)^2 * len2 <= (32768*mag)^2, found one bit at a time.
  // u = t^2*len2 for t = 2q-1, a = 4b*t*len2 and b2 = 4b^2*len2 for bit b.
  always_comb begin
    unique case (cmd.comp)
      hns_pkg::COMP_X: mag2 = ax2_r;
      hns_pkg::COMP_Y: mag2 = hns_pkg::AY_SQ;
      default:         mag2 = az2_r;
    endcase
  end

  assign take  = (qc_r <= hns_pkg::Q_MAX) && (uc_r <= r_r);
  assign q_dec = take ? qc_r : q_r;

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      u_r   <= len2_r;
      a_r   <= -(len2_r <<< 16);
      b_r   <= len2_r <<< 30;
      r_r   <= WIDE'(mag2) <<< 30;
      q_r   <= '0;
      bit_r <= hns_pkg::QW'(1) << (hns_pkg::QW - 1);
    end
    if (cmd.cand) begin
      uc_r <= u_r + a_r + b_r;
      qc_r <= q_r | bit_r;
    end
    if (cmd.decide) begin
      q_r   <= q_dec;
      bit_r <= bit_r >> 1;
      if (take) begin
        u_r <= uc_r;
        a_r <= (a_r + (b_r <<< 1)) >>> 1;
      end else begin
        a_r <= a_r >>> 1;
      end
      b_r <= b_r >>> 2;
    end
    if (cmd.store)
      res_r[cmd.comp] <= q_dec;
  end

  // Output register.
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.norm_x <= nx_r ? -$signed({1'b0, res_r[hns_pkg::COMP_X]}) :
                             $signed({1'b0, res_r[hns_pkg::COMP_X]});
      out_r.norm_y <= res_r[hns_pkg::COMP_Y];
      out_r.norm_z <= nz_r ? -$signed({1'b0, res_r[hns_pkg::COMP_Z]}) :
                             $signed({1'b0, res_r[hns_pkg::COMP_Z]});
      out_r.column <= x_r;
      out_r.row    <= 12'(y_r - YW'(1));
      out_r.end_of_image <= flush_r && ((XW+1)'(x_r) == w_r - (XW+1)'(1));
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule

FILE: sv/heightmap_normal_stream.sv
// Top level of the heightmap normal stream: sequencer plus datapath.
// An emitting item passes the buffer write and the products, the squares, the squared length, the
// three components in turn in the shared bit-serial normalizer and the load of the output register.
// A new item is accepted only when the sequencer is idle, so each item, emitting or from row 0,
// is finished before the next is taken; a result still held in the output register stalls the
// next item at its end. Reset (rst_n low, synchronous) clears the counters and the sequencer and
// loads register defaults; row buffers stay as is.
module heightmap_normal_stream (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [hns_pkg::SCFG-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  hns_pkg::in_t             in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output hns_pkg::out_t            out_data
);

  // Commands go from the sequencer to the datapath, status comes back.
  hns_pkg::cmd_t cmd;
  hns_pkg::sts_t sts;

  hns_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the row buffers, the counters and the output register.
  hns_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
